// File: hdl/ghsc_pkg.sv
// Shared constants, types, microcode store and tanh table for the gated high-pass soft clipper.
`timescale 1ns / 1ps
`default_nettype none

package ghsc_pkg;

  // Sample and filter state formats.
  localparam int SAMPLE_BITS  = 24;
  localparam int SFRAC        = SAMPLE_BITS - 1;
  localparam int STATE_BITS   = SAMPLE_BITS + 2;
  localparam int HP_SUM_BITS  = STATE_BITS + 2;

  // Configuration register formats.
  localparam int GAIN_BITS      = 16;
  localparam int GAIN_FRAC      = 12;
  localparam int THR_BITS       = 23;
  localparam int COEF_BITS      = 23;
  localparam int COEF_FRAC      = 23;
  localparam int NORM_BITS      = 17;
  localparam int CFG_DATA_BITS  = 23;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [GAIN_BITS-1:0] INPUT_GAIN_RST     = 16'd4096;
  localparam logic [GAIN_BITS-1:0] OUTPUT_GAIN_RST    = 16'd4096;
  localparam logic [THR_BITS-1:0]  GATE_THRESHOLD_RST = 23'd0;
  localparam logic [COEF_BITS-1:0] HP_COEFF_RST       = 23'd8380000;
  localparam logic [GAIN_BITS-1:0] DRIVE_RST          = 16'd4096;
  localparam logic [NORM_BITS-1:0] CLIP_NORM_RST      = 17'd65536;

  // Drive values at or below 1.01 in Q4.12 skip the soft clip.
  localparam logic [GAIN_BITS-1:0] DRIVE_BYPASS_MAX = 16'd4136;

  // Soft clip argument and tanh table geometry.
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int ROM_ENTRIES      = TANH_TABLE_DEPTH + 1;
  localparam int ROM_ADDR_BITS    = $clog2(ROM_ENTRIES);
  localparam int IDX_BITS         = $clog2(TANH_TABLE_DEPTH);
  localparam int ARG_FRAC         = SFRAC + 3;
  localparam int WEIGHT_BITS      = ARG_FRAC - IDX_BITS;
  localparam int ARG_BITS         = STATE_BITS + GAIN_BITS - GAIN_FRAC + 1;
  localparam int MAG_BITS         = ARG_BITS - 1;
  localparam int TFRAC            = 30;
  localparam int CLIP_SHIFT       = 46 - SFRAC;
  localparam int TAYLOR_TERMS     = 16;
  localparam logic [63:0] EXP_M1_Q30 = 64'd395007542;

  // Shared multiplier: signed A times unsigned B.
  localparam int MUL_A_BITS = 32;
  localparam int MUL_B_BITS = 23;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS + 1;

  localparam int STEP_BITS = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_INPUT_GAIN,
    CFG_OUTPUT_GAIN,
    CFG_GATE_THRESHOLD,
    CFG_HP_COEFF,
    CFG_DRIVE,
    CFG_CLIP_NORM
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_BITS-1:0] input_gain;
    logic [GAIN_BITS-1:0] output_gain;
    logic [THR_BITS-1:0]  gate_threshold;
    logic [COEF_BITS-1:0] hp_coeff;
    logic [GAIN_BITS-1:0] drive;
    logic [NORM_BITS-1:0] clip_norm;
  } cfg_t;

  // Microprogram steps, in program order.
  typedef enum logic [STEP_BITS-1:0] {
    S_IDLE,
    S_MUL_IG,
    S_MONO,
    S_GATE,
    S_HP,
    S_DRIVE,
    S_ARG,
    S_MAG,
    S_RD0,
    S_RD1,
    S_INTERP_MUL,
    S_INTERP,
    S_NORM_MUL,
    S_NORM,
    S_VSEL,
    S_OG_MUL,
    S_OUT
  } step_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_X_IG,
    MUL_PO_CO,
    MUL_HP_DRIVE,
    MUL_D_W,
    MUL_T_NORM,
    MUL_V_OG
  } mul_sel_e;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_LOAD,
    WR_MONO,
    WR_GATE,
    WR_HP,
    WR_ARG,
    WR_MAG,
    WR_T0,
    WR_T,
    WR_C,
    WR_V,
    WR_OUT
  } wr_sel_e;

  typedef enum logic [1:0] {
    ROM_NONE,
    ROM_LO,
    ROM_HI
  } rom_sel_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_BYPASS,
    JMP_WAIT_OUT,
    JMP_ALWAYS
  } jmp_e;

  typedef struct packed {
    mul_sel_e mul;
    wr_sel_e  wr;
    rom_sel_e rom;
    jmp_e     jmp;
    step_e    target;
  } ucode_t;

  typedef struct packed {
    mul_sel_e mul;
    wr_sel_e  wr;
    rom_sel_e rom;
  } dp_ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
    logic bypass;
  } seq_cond_t;

  typedef struct packed {
    logic bypass;
  } dp_status_t;

  typedef logic [TFRAC-1:0] tanh_rom_t [ROM_ENTRIES];

  // Control store: one control word per step.
  function automatic ucode_t ucode(input step_e s);
    ucode_t w;
    w.mul    = MUL_NONE;
    w.wr     = WR_NONE;
    w.rom    = ROM_NONE;
    w.jmp    = JMP_NEXT;
    w.target = S_IDLE;
    unique case (s)
      S_IDLE: begin
        w.wr  = WR_LOAD;
        w.jmp = JMP_WAIT_IN;
      end
      S_MUL_IG:     w.mul = MUL_X_IG;
      S_MONO:       w.wr = WR_MONO;
      S_GATE: begin
        w.wr  = WR_GATE;
        w.mul = MUL_PO_CO;
      end
      S_HP:         w.wr = WR_HP;
      S_DRIVE: begin
        w.mul    = MUL_HP_DRIVE;
        w.jmp    = JMP_BYPASS;
        w.target = S_VSEL;
      end
      S_ARG:        w.wr = WR_ARG;
      S_MAG:        w.wr = WR_MAG;
      S_RD0:        w.rom = ROM_LO;
      S_RD1: begin
        w.wr  = WR_T0;
        w.rom = ROM_HI;
      end
      S_INTERP_MUL: w.mul = MUL_D_W;
      S_INTERP:     w.wr = WR_T;
      S_NORM_MUL:   w.mul = MUL_T_NORM;
      S_NORM:       w.wr = WR_C;
      S_VSEL:       w.wr = WR_V;
      S_OG_MUL:     w.mul = MUL_V_OG;
      S_OUT: begin
        w.wr     = WR_OUT;
        w.jmp    = JMP_WAIT_OUT;
        w.target = S_IDLE;
      end
      default: begin
        w.jmp    = JMP_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // Unsigned quotient by restoring shift and subtract; only used to build the constant table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One tanh table entry, tanh(8*i/DEPTH) in Q0.30, evaluated at elaboration.
  function automatic logic [TFRAC-1:0] tanh_entry(input int unsigned idx);
    logic [63:0] one;
    logic [63:0] u;
    logic [63:0] f;
    logic [63:0] n;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] num;
    one  = 64'd1 << TFRAC;
    u    = (64'(idx) << (TFRAC + 4)) / TANH_TABLE_DEPTH;
    f    = u & (one - 64'd1);
    n    = u >> TFRAC;
    term = one;
    sum  = one;
    // Alternating series for e^-f with truncated terms.
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = udiv64((term * f) >> TFRAC, 64'(k));
      if (k[0]) sum = sum - term;
      else      sum = sum + term;
    end
    // Whole part of the exponent, one rounded factor of e^-1 at a time.
    for (int j = 0; 64'(j) < n; j++) begin
      sum = (sum * EXP_M1_Q30 + (one >> 1)) >> TFRAC;
    end
    den = one + sum;
    num = ((one - sum) << TFRAC) + (den >> 1);
    return TFRAC'(udiv64(num, den));
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    for (int i = 0; i < ROM_ENTRIES; i++) begin
      rom[i] = tanh_entry(i);
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

// File: hdl/gated_highpass_soft_clipper_unit.sv
// Top level of the gated high-pass soft clipper: ports, configuration registers, output slot.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    sample_in_i, source_valid_i, frame_last_i
//   out      output     out_valid_o / out_ready_i  sample_out_o, frame_last_out_o
//   cfg      input      cfg_we_i (no wait)         cfg_index_i, cfg_wdata_i
//
// A sample runs through the microprogram steps from its input transfer to its registered
// result, and the soft clip steps are skipped when drive is at or below 1.01; the
// microprogram uses its one shared 32 x 23 multiplier at most once per step.
// Reset clears the step counter, the output valid, the filter state and the registers to
// their reset values; the tanh table is constant, so no fill or clearing pass follows.
// The next sample is taken while a result waits in the output register; a stalled output
// holds the program at its last step until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module gated_highpass_soft_clipper_unit import ghsc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          source_valid_i,
  input  logic                          frame_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          frame_last_out_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       idle;
  logic       in_fire;
  logic       out_free;
  dp_ctrl_t   ctrl;
  dp_status_t status;
  seq_cond_t  cond;

  // Configuration register writes, masked to each register's width.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INPUT_GAIN:     cfg_d.input_gain     = cfg_wdata_i[GAIN_BITS-1:0];
        CFG_OUTPUT_GAIN:    cfg_d.output_gain    = cfg_wdata_i[GAIN_BITS-1:0];
        CFG_GATE_THRESHOLD: cfg_d.gate_threshold = cfg_wdata_i[THR_BITS-1:0];
        CFG_HP_COEFF:       cfg_d.hp_coeff       = cfg_wdata_i[COEF_BITS-1:0];
        CFG_DRIVE:          cfg_d.drive          = cfg_wdata_i[GAIN_BITS-1:0];
        CFG_CLIP_NORM:      cfg_d.clip_norm      = cfg_wdata_i[NORM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_gain     <= INPUT_GAIN_RST;
      cfg_q.output_gain    <= OUTPUT_GAIN_RST;
      cfg_q.gate_threshold <= GATE_THRESHOLD_RST;
      cfg_q.hp_coeff       <= HP_COEFF_RST;
      cfg_q.drive          <= DRIVE_RST;
      cfg_q.clip_norm      <= CLIP_NORM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake conditions for the sequencer.
  assign in_ready_o    = idle;
  assign in_fire       = in_valid_i && idle;
  assign out_free      = !out_valid_q || out_ready_i;
  assign cond.in_fire  = in_fire;
  assign cond.out_free = out_free;
  assign cond.bypass   = status.bypass;

  // Output slot: filled by the last step, emptied by an output transfer.
  assign out_valid_d = (ctrl.wr == WR_OUT) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  ghsc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .ctrl_o (ctrl),
    .idle_o (idle)
  );

  ghsc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .cfg_i            (cfg_q),
    .sample_in_i      (sample_in_i),
    .source_valid_i   (source_valid_i),
    .frame_last_i     (frame_last_i),
    .status_o         (status),
    .sample_out_o     (sample_out_o),
    .frame_last_out_o (frame_last_out_o)
  );

  // A sample is loaded only on an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr == WR_LOAD) |-> in_fire)
    else $error("input registers loaded without an input transfer");

  // A result is never written over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.wr == WR_OUT) |-> out_free)
    else $error("output register overwritten while still holding a result");

  // Only one sample is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input ready one cycle after an input transfer");

endmodule

`default_nettype wire

// File: hdl/ghsc_seq.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
`default_nettype none

module ghsc_seq import ghsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seq_cond_t cond_i,
  output dp_ctrl_t  ctrl_o,
  output logic      idle_o
);

  step_e  step_q;
  step_e  step_d;
  step_e  step_inc;
  ucode_t uword;
  logic   go;

  assign uword    = ucode(step_q);
  assign step_inc = step_e'(step_q + STEP_BITS'(1));
  assign idle_o   = (step_q == S_IDLE);

  // Evaluate the jump condition of the current control word.
  always_comb begin
    unique case (uword.jmp)
      JMP_WAIT_IN:  go = cond_i.in_fire;
      JMP_WAIT_OUT: go = cond_i.out_free;
      JMP_BYPASS:   go = cond_i.bypass;
      default:      go = 1'b1;
    endcase
  end

  // Next step.
  always_comb begin
    step_d = step_q;
    unique case (uword.jmp)
      JMP_NEXT:     step_d = step_inc;
      JMP_WAIT_IN:  if (go) step_d = step_inc;
      JMP_BYPASS:   step_d = go ? uword.target : step_inc;
      JMP_WAIT_OUT: if (go) step_d = uword.target;
      default:      step_d = uword.target;
    endcase
  end

  // Datapath controls; a waiting step writes nothing until its transfer happens.
  always_comb begin
    ctrl_o.mul = uword.mul;
    ctrl_o.rom = uword.rom;
    ctrl_o.wr  = uword.wr;
    if ((uword.jmp == JMP_WAIT_IN || uword.jmp == JMP_WAIT_OUT) && !go) begin
      ctrl_o.wr = WR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ghsc_datapath.sv
// Datapath: shared multiplier, working registers, filter state and tanh table.
`timescale 1ns / 1ps
`default_nettype none

module ghsc_datapath import ghsc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dp_ctrl_t                      ctrl_i,
  input  cfg_t                          cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          source_valid_i,
  input  logic                          frame_last_i,
  output dp_status_t                    status_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          frame_last_out_o
);

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] mono_q;
  logic signed [SAMPLE_BITS-1:0] prev_in_q;
  logic signed [SAMPLE_BITS-1:0] out_q;
  logic                          frame_q;
  logic                          out_frame_q;
  logic signed [STATE_BITS-1:0]  prev_out_q;
  logic signed [STATE_BITS-1:0]  c_q;
  logic signed [STATE_BITS-1:0]  v_q;
  logic signed [ARG_BITS-1:0]    arg_q;
  logic [MAG_BITS-1:0]           mag_q;
  logic [TFRAC-1:0]              rom_q;
  logic [TFRAC-1:0]              t0_q;
  logic [TFRAC-1:0]              t_q;
  logic signed [PROD_BITS-1:0]   prod_q;

  logic signed [MUL_A_BITS-1:0]  opa;
  logic [MUL_B_BITS-1:0]         opb;
  logic signed [PROD_BITS-1:0]   mul_res;
  logic [SAMPLE_BITS-1:0]        mono_mag;
  logic signed [HP_SUM_BITS-1:0] hp_sum;
  logic signed [STATE_BITS-1:0]  hp_sat;
  logic signed [STATE_BITS-1:0]  clip_val;
  logic                          big;
  logic [IDX_BITS-1:0]           idx;
  logic [WEIGHT_BITS-1:0]        weight;
  logic [ROM_ADDR_BITS-1:0]      rom_addr;
  logic signed [TFRAC:0]         t_diff;
  logic                          bypass;

  // Add half an LSB, then shift right with floor.
  function automatic logic signed [PROD_BITS-1:0] round_shift(
    input logic signed [PROD_BITS-1:0] v,
    input int unsigned                 sh
  );
    logic signed [PROD_BITS-1:0] half;
    half = PROD_BITS'(1) << (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [PROD_BITS-1:0] v
  );
    logic [PROD_BITS-SAMPLE_BITS:0] hi_bits;
    hi_bits = v[PROD_BITS-1:SAMPLE_BITS-1];
    if (hi_bits == '0 || hi_bits == '1) return v[SAMPLE_BITS-1:0];
    else if (v[PROD_BITS-1]) return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    else return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [HP_SUM_BITS-1:0] v
  );
    logic [HP_SUM_BITS-STATE_BITS:0] hi_bits;
    hi_bits = v[HP_SUM_BITS-1:STATE_BITS-1];
    if (hi_bits == '0 || hi_bits == '1) return v[STATE_BITS-1:0];
    else if (v[HP_SUM_BITS-1]) return {1'b1, {(STATE_BITS-1){1'b0}}};
    else return {1'b0, {(STATE_BITS-1){1'b1}}};
  endfunction

  assign bypass          = (cfg_i.drive <= DRIVE_BYPASS_MAX);
  assign status_o.bypass = bypass;

  // Gate magnitude; the most negative sample maps to 2^(SAMPLE_BITS-1).
  assign mono_mag = mono_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-mono_q) : mono_q;

  // High-pass sum, saturated to the state width.
  assign hp_sum = HP_SUM_BITS'(mono_q) - HP_SUM_BITS'(prev_in_q)
                + HP_SUM_BITS'(round_shift(prod_q, COEF_FRAC));
  assign hp_sat = sat_state(hp_sum);

  // Table index and interpolation weight; arguments of 8.0 or more use the last entry.
  assign big    = |mag_q[MAG_BITS-1:ARG_FRAC];
  assign idx    = mag_q[ARG_FRAC-1:WEIGHT_BITS];
  assign weight = mag_q[WEIGHT_BITS-1:0];
  assign t_diff = $signed({1'b0, rom_q}) - $signed({1'b0, t0_q});

  always_comb begin
    unique case (ctrl_i.rom)
      ROM_HI:  rom_addr = big ? ROM_ADDR_BITS'(TANH_TABLE_DEPTH)
                              : ROM_ADDR_BITS'(idx) + ROM_ADDR_BITS'(1);
      default: rom_addr = big ? ROM_ADDR_BITS'(TANH_TABLE_DEPTH) : ROM_ADDR_BITS'(idx);
    endcase
  end

  // Soft clip result takes the sign of the high-pass output.
  assign clip_val = prev_out_q[STATE_BITS-1] ? -c_q : c_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctrl_i.mul)
      MUL_X_IG: begin
        opa = MUL_A_BITS'(x_q);
        opb = MUL_B_BITS'(cfg_i.input_gain);
      end
      MUL_PO_CO: begin
        opa = MUL_A_BITS'(prev_out_q);
        opb = MUL_B_BITS'(cfg_i.hp_coeff);
      end
      MUL_HP_DRIVE: begin
        opa = MUL_A_BITS'(prev_out_q);
        opb = MUL_B_BITS'(cfg_i.drive);
      end
      MUL_D_W: begin
        opa = MUL_A_BITS'(t_diff);
        opb = big ? '0 : MUL_B_BITS'(weight);
      end
      MUL_T_NORM: begin
        opa = MUL_A_BITS'($signed({1'b0, t_q}));
        opb = MUL_B_BITS'(cfg_i.clip_norm);
      end
      MUL_V_OG: begin
        opa = MUL_A_BITS'(v_q);
        opb = MUL_B_BITS'(cfg_i.output_gain);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul_res = opa * $signed({1'b0, opb});

  // Product register and table read register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul != MUL_NONE) prod_q <= mul_res;
    if (ctrl_i.rom != ROM_NONE) rom_q <= TANH_ROM[rom_addr];
  end

  // Working registers, written as the control word selects.
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.wr)
      WR_LOAD: begin
        x_q     <= source_valid_i ? sample_in_i : '0;
        frame_q <= frame_last_i;
      end
      WR_MONO: mono_q <= sat_sample(round_shift(prod_q, GAIN_FRAC));
      WR_GATE: if (mono_mag < SAMPLE_BITS'(cfg_i.gate_threshold)) mono_q <= '0;
      WR_ARG:  arg_q <= ARG_BITS'(round_shift(prod_q, GAIN_FRAC));
      WR_MAG:  mag_q <= MAG_BITS'(arg_q[ARG_BITS-1] ? -arg_q : arg_q);
      WR_T0:   t0_q <= rom_q;
      WR_T:    t_q <= t0_q + TFRAC'(prod_q >>> WEIGHT_BITS);
      WR_C:    c_q <= STATE_BITS'(round_shift(prod_q, CLIP_SHIFT));
      WR_V:    v_q <= bypass ? prev_out_q : clip_val;
      WR_OUT: begin
        out_q       <= sat_sample(round_shift(prod_q, GAIN_FRAC));
        out_frame_q <= frame_q;
      end
      default: ;
    endcase
  end

  // Filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_in_q  <= '0;
      prev_out_q <= '0;
    end else if (ctrl_i.wr == WR_HP) begin
      prev_in_q  <= mono_q;
      prev_out_q <= hp_sat;
    end
  end

  assign sample_out_o     = out_q;
  assign frame_last_out_o = out_frame_q;

endmodule

`default_nettype wire

// File: verif/gated_highpass_soft_clipper_unit_test.sv
// Self-checking testbench for the gated high-pass soft clipper, with a bit-true scoreboard.
`timescale 1ns / 1ps

// One processed frame as it leaves the block.
typedef struct {
  logic signed [ghsc_pkg::SAMPLE_BITS-1:0] sample;
  logic                                    last;
} clip_frame_t;

// Scoreboard: predicts each frame from the accepted input and compares the block's output.
class clip_scoreboard;
  clip_frame_t pending_frames[$];
  int          error_count;

  // Tanh table in Q0.30, built independently of the design's copy.
  longint tanh_q30 [ghsc_pkg::ROM_ENTRIES];

  // Register copies and filter state.
  longint in_gain, out_gain, gate_thr, hp_r, drive, norm;
  longint last_mono, last_hp;

  function void init();
    longint unsigned one, u, f, n, term, e, den, num;
    one = 64'd1 << ghsc_pkg::TFRAC;
    for (int i = 0; i < ghsc_pkg::ROM_ENTRIES; i++) begin
      u    = (64'(i) << (ghsc_pkg::TFRAC + 4)) / ghsc_pkg::TANH_TABLE_DEPTH;
      f    = u & (one - 1);
      n    = u >> ghsc_pkg::TFRAC;
      term = one;
      e    = one;
      // e^-f of the fractional part by a truncated alternating series.
      for (int k = 1; k <= 16; k++) begin
        term = ((term * f) >> ghsc_pkg::TFRAC) / 64'(k);
        if (k % 2 == 1) e = e - term;
        else            e = e + term;
      end
      // Whole part: one rounded multiply by e^-1 per unit.
      for (longint unsigned j = 0; j < n; j++) begin
        e = (e * ghsc_pkg::EXP_M1_Q30 + (one >> 1)) >> ghsc_pkg::TFRAC;
      end
      den = one + e;
      num = ((one - e) << ghsc_pkg::TFRAC) + den / 2;
      tanh_q30[i] = longint'(num / den);
    end
    in_gain     = 4096;
    out_gain    = 4096;
    gate_thr    = 0;
    hp_r        = 8380000;
    drive       = 4096;
    norm        = 65536;
    last_mono   = 0;
    last_hp     = 0;
    error_count = 0;
  endfunction

  function void set_reg(ghsc_pkg::cfg_idx_e idx, logic [ghsc_pkg::CFG_DATA_BITS-1:0] val);
    case (idx)
      ghsc_pkg::CFG_INPUT_GAIN:     in_gain  = longint'(val[15:0]);
      ghsc_pkg::CFG_OUTPUT_GAIN:    out_gain = longint'(val[15:0]);
      ghsc_pkg::CFG_GATE_THRESHOLD: gate_thr = longint'(val[22:0]);
      ghsc_pkg::CFG_HP_COEFF:       hp_r     = longint'(val[22:0]);
      ghsc_pkg::CFG_DRIVE:          drive    = longint'(val[15:0]);
      ghsc_pkg::CFG_CLIP_NORM:      norm     = longint'(val[16:0]);
      default: ;
    endcase
  endfunction

  // Add half an LSB, then shift right with floor.
  function longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function longint sat(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // Soft clip: tanh(v * drive) from the interpolated table, scaled by the norm.
  function longint shape(longint v);
    longint a, mag, p, w, t0, t1, t, c;
    int     idx;
    a   = round_sh(v * drive, ghsc_pkg::GAIN_FRAC);
    mag = (a < 0) ? -a : a;
    if (mag >= (64'sd8 <<< ghsc_pkg::SFRAC)) begin
      t = tanh_q30[ghsc_pkg::TANH_TABLE_DEPTH];
    end else begin
      p   = mag * ghsc_pkg::TANH_TABLE_DEPTH;
      idx = int'(p >>> ghsc_pkg::ARG_FRAC);
      w   = p & ((64'sd1 <<< ghsc_pkg::ARG_FRAC) - 1);
      t0  = tanh_q30[idx];
      t1  = tanh_q30[idx + 1];
      t   = t0 + (((t1 - t0) * w) >>> ghsc_pkg::ARG_FRAC);
    end
    c = round_sh(t * norm, 46 - ghsc_pkg::SFRAC);
    return (v < 0) ? -c : c;
  endfunction

  // Predict the frame caused by one accepted input transfer.
  function void note_input(logic signed [ghsc_pkg::SAMPLE_BITS-1:0] s, logic src, logic last);
    longint      x, mono, mag, hp, v;
    clip_frame_t fr;
    x    = src ? longint'(s) : 0;
    mono = sat(round_sh(x * in_gain, ghsc_pkg::GAIN_FRAC), ghsc_pkg::SAMPLE_BITS);
    mag  = (mono < 0) ? -mono : mono;
    if (mag < gate_thr) mono = 0;
    hp = sat(mono - last_mono + round_sh(hp_r * last_hp, ghsc_pkg::COEF_FRAC),
             ghsc_pkg::STATE_BITS);
    last_mono = mono;
    last_hp   = hp;
    v = (drive <= longint'(ghsc_pkg::DRIVE_BYPASS_MAX)) ? hp : shape(hp);
    fr.sample = ghsc_pkg::SAMPLE_BITS'(sat(round_sh(v * out_gain, ghsc_pkg::GAIN_FRAC),
                                           ghsc_pkg::SAMPLE_BITS));
    fr.last   = last;
    pending_frames.push_back(fr);
  endfunction

  task report(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Compare one output transfer with the oldest prediction.
  task check_output(logic signed [ghsc_pkg::SAMPLE_BITS-1:0] s, logic last);
    clip_frame_t fr;
    if (pending_frames.size() == 0) begin
      report($sformatf("output sample %0d with nothing predicted", s));
    end else begin
      fr = pending_frames.pop_front();
      if (s !== fr.sample)
        report($sformatf("sample_out got %0d, predicted %0d", s, fr.sample));
      if (last !== fr.last)
        report($sformatf("frame_last_out got %b, predicted %b", last, fr.last));
    end
  endtask
endclass

module gated_highpass_soft_clipper_unit_test;
  import ghsc_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [CFG_INDEX_BITS-1:0]     CFG_UNUSED_IDX = 3'd7;
  localparam int                            RAND_PHASES      = 6;
  localparam int                            PHASE_ITEMS      = 316;
  localparam int                            TAIL_CYCLES      = 40;
  localparam int                            LONG_HOLD_CYCLES = 400;
  localparam int                            TIMEOUT_NS       = 8_000_000;

  logic                          clk_i;
  logic                          rst_ni           = 1'b0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_in_i      = '0;
  logic                          source_valid_i   = 1'b0;
  logic                          frame_last_i     = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i      = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;
  logic                          frame_last_out_o;
  logic                          cfg_we_i         = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index_i      = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata_i      = '0;

  clip_scoreboard                sb;
  int                            snd_idle_pct = 22;
  int                            rcv_idle_pct = 47;
  bit                            hold_request = 1'b0;
  logic signed [SAMPLE_BITS-1:0] prev_sample  = '0;

  gated_highpass_soft_clipper_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_in_i      (sample_in_i),
    .source_valid_i   (source_valid_i),
    .frame_last_i     (frame_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_out_o     (sample_out_o),
    .frame_last_out_o (frame_last_out_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("gated_highpass_soft_clipper_unit_test: done, errors");
    $finish;
  end

  // Output side: check each transfer, then choose ready for the next cycle.
  // A long hold-off, when requested, lets the block fill up and stall its input.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) sb.check_output(sample_out_o, frame_last_out_o);
      if (hold_request) begin
        hold_left    = LONG_HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Offer one input item after a random gap and wait for its transfer.
  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input logic src,
                           input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_in_i    <= s;
    source_valid_i <= src;
    frame_last_i   <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(s, src, last);
  endtask

  // Stop offering, wait for every predicted frame, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // Write all six registers back to back, optionally followed by an unused index.
  task automatic load_setting(input logic [CFG_DATA_BITS-1:0] ig, og, thr, hpc, drv, nrm,
                              input bit with_unused);
    logic [CFG_DATA_BITS-1:0] vals [6];
    vals = '{ig, og, thr, hpc, drv, nrm};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    if (with_unused) begin
      cfg_index_i <= CFG_UNUSED_IDX;
      cfg_wdata_i <= '1;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Uniform in [lo, hi], with each end picked more often.
  function automatic int unsigned pick_range(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Random sample: full scale, small of either sign, extremes or a held level.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    s = SAMPLE_BITS'($urandom);
    case ($urandom_range(9))
      0:       s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2, 3: s = s >>> $urandom_range(SAMPLE_BITS - 2);
      4:       s = prev_sample;
      default: ;
    endcase
    return s;
  endfunction

  // Main sequence: reset, directed groups, then random phases under each idling pattern.
  initial begin : stimulus
    logic signed [SAMPLE_BITS-1:0] s;
    logic [CFG_DATA_BITS-1:0]      ig, og, thr, hpc, drv, nrm;
    sb = new;
    sb.init();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: unity gains, no gate, soft clip bypassed; silence still runs the filter.
    send_item('0, 1'b1, 1'b0);
    send_item(SAMPLE_MAX, 1'b1, 1'b0);
    send_item(SAMPLE_MIN, 1'b1, 1'b1);
    send_item(24'sd1, 1'b1, 1'b0);
    send_item(-24'sd1, 1'b1, 1'b0);
    send_item(SAMPLE_MAX, 1'b0, 1'b1);
    drain();

    // Gain overflow into saturated mono, filter state and output; drive at the bypass edge.
    load_setting(23'd65535, 23'd65535, 23'd0, 23'd8388607, 23'(DRIVE_BYPASS_MAX), 23'd65536,
                 1'b0);
    send_item(SAMPLE_MAX, 1'b1, 1'b0);
    send_item(SAMPLE_MIN, 1'b1, 1'b0);
    send_item(SAMPLE_MIN, 1'b1, 1'b1);
    send_item(SAMPLE_MAX, 1'b1, 1'b0);
    drain();

    // Gate either side of its threshold; drive just above bypass; clip norm below one.
    load_setting(23'd4096, 23'd4096, 23'd1000, 23'd0, 23'(DRIVE_BYPASS_MAX) + 23'd1,
                 23'd65535, 1'b0);
    send_item(24'sd999, 1'b1, 1'b0);
    send_item(-24'sd999, 1'b1, 1'b0);
    send_item(24'sd1000, 1'b1, 1'b0);
    send_item(-24'sd1000, 1'b1, 1'b1);
    send_item(24'sd500000, 1'b1, 1'b0);
    drain();

    // Highest drive and norm: arguments past the end of the table and tiny ones.
    load_setting(23'd4096, 23'd4096, 23'd0, 23'd8380000, 23'd65535, 23'd131071, 1'b0);
    send_item(SAMPLE_MAX, 1'b1, 1'b0);
    send_item(SAMPLE_MIN, 1'b1, 1'b0);
    send_item(24'sd100, 1'b1, 1'b0);
    send_item(-24'sd100, 1'b1, 1'b1);
    send_item(24'sd12, 1'b0, 1'b0);
    drain();

    // Drive below one is bypassed; zero norm; a write to an unused index changes nothing.
    load_setting(23'd4096, 23'd4096, 23'd0, 23'd8380000, 23'd0, 23'd0, 1'b1);
    send_item(24'sd12345, 1'b1, 1'b0);
    send_item(-24'sd12345, 1'b1, 1'b1);
    drain();

    // Random phases: two per idling pattern, with a long output hold-off in two of them.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          snd_idle_pct = 22;
          rcv_idle_pct = 47;
        end
        1: begin
          snd_idle_pct = 47;
          rcv_idle_pct = 22;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (ph == 1) begin
        load_setting(23'd65535, 23'd65535, 23'd8388607, 23'd8388607, 23'd65535, 23'd131071,
                     1'b0);
      end else begin
        ig  = 23'(pick_range(0, 12288)) | (23'($urandom) & ~23'hFFFF);
        og  = 23'(pick_range(0, 8192)) | (23'($urandom) & ~23'hFFFF);
        thr = ($urandom_range(3) == 0) ? 23'(pick_range(0, 8388607))
                                       : 23'($urandom_range(65536));
        hpc = 23'(pick_range(0, 8388607));
        case ($urandom_range(9))
          0:       drv = 23'(DRIVE_BYPASS_MAX);
          1:       drv = 23'd65535;
          2:       drv = 23'($urandom_range(DRIVE_BYPASS_MAX));
          default: drv = 23'($urandom_range(65535, DRIVE_BYPASS_MAX + 1));
        endcase
        drv = drv | (23'($urandom) & ~23'hFFFF);
        nrm = ($urandom_range(4) == 0) ? 23'($urandom_range(65535))
                                       : 23'(pick_range(65536, 131071));
        nrm = nrm | (23'($urandom) & ~23'h1FFFF);
        load_setting(ig, og, thr, hpc, drv, nrm, 1'b0);
      end
      if (ph == 0 || ph == 4) hold_request = 1'b1;
      repeat (PHASE_ITEMS) begin
        s = random_sample();
        prev_sample = s;
        send_item(s, $urandom_range(9) != 0, $urandom_range(7) == 0);
      end
      drain();
    end

    if (sb.pending_frames.size() != 0)
      sb.report($sformatf("%0d predicted frames never arrived", sb.pending_frames.size()));
    if (sb.error_count == 0) begin
      $display("gated_highpass_soft_clipper_unit_test: done, clean");
    end else begin
      $display("gated_highpass_soft_clipper_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ghsc_pkg.sv
hdl/ghsc_seq.sv
hdl/ghsc_datapath.sv
hdl/gated_highpass_soft_clipper_unit.sv
verif/gated_highpass_soft_clipper_unit_test.sv
